// File: rtl/core/tlp_pkg.sv
package tlp_pkg;

    localparam int MAX_LINE_DEF = 160;
    localparam int WINDOW       = 18;
    localparam int NUM_KW       = 5;
    localparam int NUM_PAT      = NUM_KW + 1;
    localparam int PAT_MM       = NUM_KW;

    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;

    localparam logic [4:0]  STOP_MASK   = 5'b00111;
    localparam logic [4:0]  CLEAR_MASK  = 5'b11000;
    localparam logic [19:0] RANGE_LIMIT = 20'd65535;

    localparam logic [8*17-1:0] KW0 = "EVT OBSTACLE STOP";
    localparam logic [8*18-1:0] KW1 = "ERR MOTOR obstacle";
    localparam logic [8*9-1:0]  KW2 = "blocked=1";
    localparam logic [8*18-1:0] KW3 = "EVT OBSTACLE CLEAR";
    localparam logic [8*9-1:0]  KW4 = "blocked=0";
    localparam logic [8*3-1:0]  KMM = "mm=";

    typedef enum logic [2:0] {
        PH_SEARCH = 3'd0,
        PH_KEY    = 3'd1,
        PH_DIGITS = 3'd2,
        PH_DONE   = 3'd3,
        PH_NONE   = 3'd4
    } phase_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    typedef logic [NUM_PAT-1:0] pat_vec_t;

    // Expected character of pattern pat at window position pos, with a care bit on top.
    // The pattern sits right-aligned in the window, its last character in the newest cell.
    function automatic logic [8:0] pattern_char(input int pat, input int pos);
        int len;
        int idx;
        logic [8:0] res;
        res = 9'd0;
        case (pat)
            0: len = 17;
            1: len = 18;
            2: len = 9;
            3: len = 18;
            4: len = 9;
            default: len = 3;
        endcase
        idx = pos - (WINDOW - len);
        if (idx >= 0 && idx < len) begin
            case (pat)
                0: res = {1'b1, KW0[8*(len-1-idx) +: 8]};
                1: res = {1'b1, KW1[8*(len-1-idx) +: 8]};
                2: res = {1'b1, KW2[8*(len-1-idx) +: 8]};
                3: res = {1'b1, KW3[8*(len-1-idx) +: 8]};
                4: res = {1'b1, KW4[8*(len-1-idx) +: 8]};
                default: res = {1'b1, KMM[8*(len-1-idx) +: 8]};
            endcase
        end
        return res;
    endfunction

endpackage

// File: rtl/core/tlp_cell.sv
module tlp_cell #(
    parameter int POS = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlp_pkg::cell_ctl_t   ctl,
    input  logic [7:0]           din,
    input  tlp_pkg::pat_vec_t    match_in,
    output logic [7:0]           dout,
    output tlp_pkg::pat_vec_t    match_out
);
    import tlp_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    pat_vec_t   eq;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.clear)
        begin
            byte_next = 8'd0;
        end
        else if (ctl.shift)
        begin
            byte_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // Unfilled cells hold zero, which no pattern character equals.
    always_comb
    begin
        for (int j = 0; j < NUM_PAT; j++)
        begin
            logic [8:0] pc;
            pc    = pattern_char(j, POS);
            eq[j] = !pc[8] || (byte_reg == pc[7:0]);
        end
    end

    assign dout      = byte_reg;
    assign match_out = match_in & eq;

endmodule

// File: rtl/core/telemetry_line_parser_core.sv
// Telemetry line parser.
// Input channel: in_valid / in_stall with rx_byte, one received serial byte per beat.
// Output channel: out_valid / out_stall with range_valid, range_mm, event_valid,
// obstacle_blocked and line_length, one beat per finished non-empty line.
// A line feed ends a line; carriage returns are skipped; a byte arriving on a
// full line (MAX_LINE stored bytes) clears the line and is dropped.
// Throughput is one byte per cycle while in_stall is low. The line feed that ends a line produces its
// result in the cycle after it is accepted, from the output register.
// Keywords are found by a row of WINDOW byte cells that shift in each stored
// byte; every cell compares its byte against the pattern characters at its
// position and the partial matches run down the row.
// Reset empties the line and the byte cells and clears out_valid.
// in_stall is high only while a result sits in the output register and the
// receiver stalls it; the next byte is taken in the same cycle the result leaves.
module telemetry_line_parser_core #(
    parameter int MAX_LINE = tlp_pkg::MAX_LINE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        range_valid,
    output logic [15:0] range_mm,
    output logic        event_valid,
    output logic        obstacle_blocked,
    output logic [7:0]  line_length
);
    import tlp_pkg::*;

    localparam logic [7:0] MaxLen = 8'(MAX_LINE);

    logic [7:0]  len_reg, len_next;
    logic [4:0]  flags_reg, flags_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] val_reg, val_next;
    logic        ovf_reg, ovf_next;

    logic        ov_reg, ov_next;
    logic        rv_reg, rv_next;
    logic [15:0] mm_reg, mm_next;
    logic        ev_reg, ev_next;
    logic        blk_reg, blk_next;
    logic [7:0]  ll_reg, ll_next;

    logic        accept, is_lf, is_cr, is_digit, full;
    logic        clear_line, append, emit;
    cell_ctl_t   ctl;
    logic [7:0]  win [WINDOW];
    pat_vec_t    chain [WINDOW+1];
    pat_vec_t    match;
    logic [4:0]  flags_now;
    phase_t      phase_eff;
    logic [19:0] prod;
    logic        stop_seen, clr_seen, rv_now;

    assign in_stall = ov_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign is_lf    = rx_byte == CH_LF;
    assign is_cr    = rx_byte == CH_CR;
    assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign full     = len_reg >= MaxLen;

    assign clear_line = accept && (is_lf || full);
    assign append     = accept && !is_lf && !full && !is_cr;
    assign emit       = accept && is_lf && (len_reg != 8'd0);

    assign ctl = '{shift: append, clear: clear_line};

    assign chain[0] = '1;

    genvar p;
    generate
        for (p = 0; p < WINDOW; p++)
        begin : g_cell
            logic [7:0] din;
            if (p == WINDOW - 1)
            begin : g_last
                assign din = rx_byte;
            end
            else
            begin : g_mid
                assign din = win[p+1];
            end
            tlp_cell #(
                .POS(p)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .din       (din),
                .match_in  (chain[p]),
                .dout      (win[p]),
                .match_out (chain[p+1])
            );
        end
    endgenerate

    assign match = chain[WINDOW];

    // The window changes only on a stored byte or a line clear, so a match on the current window
    // stands for the byte stored last and is folded in when the next byte is accepted.
    assign flags_now = flags_reg | match[NUM_KW-1:0];
    assign phase_eff = (phase_reg == PH_SEARCH && match[PAT_MM]) ? PH_KEY : phase_reg;

    assign prod = ({4'd0, val_reg} << 3) + ({4'd0, val_reg} << 1)
                + {12'd0, rx_byte - CH_0};

    assign stop_seen = (flags_now & STOP_MASK) != 5'd0;
    assign clr_seen  = (flags_now & CLEAR_MASK) != 5'd0;
    assign rv_now    = (phase_eff == PH_DIGITS || phase_eff == PH_DONE) && !ovf_reg;

    always_comb
    begin
        len_next   = len_reg;
        flags_next = flags_reg;
        phase_next = phase_reg;
        val_next   = val_reg;
        ovf_next   = ovf_reg;
        if (clear_line)
        begin
            len_next   = 8'd0;
            flags_next = 5'd0;
            phase_next = PH_SEARCH;
            val_next   = 16'd0;
            ovf_next   = 1'b0;
        end
        else if (append)
        begin
            len_next   = len_reg + 8'd1;
            flags_next = flags_now;
            case (phase_eff)
                PH_KEY, PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (ovf_reg || prod > RANGE_LIMIT)
                        begin
                            ovf_next = 1'b1;
                            val_next = RANGE_LIMIT[15:0];
                        end
                        else
                        begin
                            val_next = prod[15:0];
                        end
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        phase_next = (phase_eff == PH_DIGITS) ? PH_DONE : PH_NONE;
                    end
                end
                default:
                begin
                    phase_next = phase_eff;
                end
            endcase
        end
    end

    always_comb
    begin
        ov_next  = ov_reg;
        rv_next  = rv_reg;
        mm_next  = mm_reg;
        ev_next  = ev_reg;
        blk_next = blk_reg;
        ll_next  = ll_reg;
        if (emit)
        begin
            ov_next  = 1'b1;
            rv_next  = rv_now;
            mm_next  = rv_now ? val_reg : 16'd0;
            ev_next  = stop_seen || clr_seen;
            blk_next = stop_seen && !clr_seen;
            ll_next  = len_reg;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= 8'd0;
            flags_reg <= 5'd0;
            phase_reg <= PH_SEARCH;
            val_reg   <= 16'd0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            flags_reg <= flags_next;
            phase_reg <= phase_next;
            val_reg   <= val_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rv_reg  <= rv_next;
        mm_reg  <= mm_next;
        ev_reg  <= ev_next;
        blk_reg <= blk_next;
        ll_reg  <= ll_next;
    end

    assign out_valid        = ov_reg;
    assign range_valid      = rv_reg;
    assign range_mm         = mm_reg;
    assign event_valid      = ev_reg;
    assign obstacle_blocked = blk_reg;
    assign line_length      = ll_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= MaxLen)
        else $error("stored length beyond line limit");

    a_blk_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && obstacle_blocked |-> event_valid)
        else $error("blocked without event");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !range_valid |-> range_mm == 16'd0)
        else $error("range value without valid flag");

    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> line_length != 8'd0)
        else $error("result for an empty line");

    a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid && len_reg == 8'd0 && phase_reg == PH_SEARCH)
        else $error("line end did not clear line state");

endmodule
